/* rtl/core/ssc_pkg.sv */
package ssc_pkg;

  // Field widths of the contact test.
  localparam int CW    = 32;          // coordinate width, Q16.16
  localparam int NFB   = 14;          // fraction bits of the normal
  localparam int NW    = NFB + 2;     // normal output width
  localparam int DW    = CW + 1;      // centre difference magnitude width
  localparam int SQW   = 2 * DW;      // squared length width
  localparam int RTW   = DW;          // square root width
  localparam int REMW  = RTW + 2;     // square root remainder width
  localparam int QW    = NFB + 1;     // normal quotient width
  localparam int NUMW  = CW + QW;     // normal dividend width
  localparam int S2W   = CW + 3;      // doubled lever width, signed
  localparam int PW    = QW + S2W - 1; // offset product width
  localparam int CEW   = S2W + 1;     // unsaturated contact width

  // Pipeline layout: three front stages, one root cell per result bit,
  // one setup stage, one divide cell per quotient bit, then three more.
  localparam int FR_N  = 3 + RTW;
  localparam int NSTG  = FR_N + QW + 4;

  localparam logic [15:0] EPS_RESET = 16'd7;

  // Data carried alongside the square root cells.
  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0]         dneg;
    logic [2:0][DW-1:0] dmag;
    logic [CW-2:0]      ra;
    logic [CW-2:0]      rb;
  } fr_ctx_t;

  // Data carried alongside the divide cells and the output stages.
  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0]         dneg;
    logic               hit;
    logic               near;
    logic [CW-1:0]      pen;
    logic [S2W-1:0]     s2;
  } bk_ctx_t;

endpackage

/* rtl/core/ssc_sqrt_cell.sv */
module ssc_sqrt_cell (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ssc_pkg::REMW-1:0] rem_i,
  input  logic [ssc_pkg::RTW-1:0]  root_i,
  input  logic [ssc_pkg::SQW-1:0]  rad_i,
  output logic [ssc_pkg::REMW-1:0] rem_o,
  output logic [ssc_pkg::RTW-1:0]  root_o,
  output logic [ssc_pkg::SQW-1:0]  rad_o
);
  import ssc_pkg::*;

  logic [REMW+1:0] cur;
  logic [REMW+1:0] trial;
  logic [REMW-1:0] rem_d;
  logic [RTW-1:0]  root_d;

  // One result bit: bring down two radicand bits and try the next root bit.
  always_comb begin
    cur   = {rem_i, rad_i[SQW-1 -: 2]};
    trial = (REMW + 2)'({root_i, 2'b01});
    if (cur >= trial) begin
      rem_d  = REMW'(cur - trial);
      root_d = {root_i[RTW-2:0], 1'b1};
    end else begin
      rem_d  = cur[REMW-1:0];
      root_d = {root_i[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      rad_o  <= {rad_i[SQW-3:0], 2'b00};
    end
  end

endmodule

/* rtl/core/ssc_div_cell.sv */
module ssc_div_cell (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [ssc_pkg::CW-1:0] den_i,
  input  logic [ssc_pkg::CW-1:0] rem_i,
  input  logic [ssc_pkg::QW-1:0] low_i,
  input  logic [ssc_pkg::QW-1:0] quo_i,
  output logic [ssc_pkg::CW-1:0] den_o,
  output logic [ssc_pkg::CW-1:0] rem_o,
  output logic [ssc_pkg::QW-1:0] low_o,
  output logic [ssc_pkg::QW-1:0] quo_o
);
  import ssc_pkg::*;

  logic [CW:0]   cur;
  logic [CW-1:0] rem_d;
  logic [QW-1:0] quo_d;

  // One quotient bit of a restoring division.
  always_comb begin
    cur = {rem_i, low_i[QW-1]};
    if (cur >= {1'b0, den_i}) begin
      rem_d = CW'(cur - {1'b0, den_i});
      quo_d = {quo_i[QW-2:0], 1'b1};
    end else begin
      rem_d = cur[CW-1:0];
      quo_d = {quo_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      rem_o <= rem_d;
      low_o <= {low_i[QW-2:0], 1'b0};
      quo_o <= quo_d;
    end
  end

endmodule

/* rtl/core/sphere_sphere_contact_top.sv */
// Sphere pair contact test, fully pipelined through a row of root cells
// (one per distance bit) and three rows of divide cells (one per normal bit).
// Throughput: one pair per cycle. A skid register behind the output takes a
// stalled result, and the pipeline holds only while that register is full.
// Reset clears all valid bits and sets the near-zero distance threshold to 7.
module sphere_sphere_contact_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [15:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [ssc_pkg::CW-1:0] center_a_x_i,
  input  logic signed [ssc_pkg::CW-1:0] center_a_y_i,
  input  logic signed [ssc_pkg::CW-1:0] center_a_z_i,
  input  logic [ssc_pkg::CW-2:0]     radius_a_i,
  input  logic signed [ssc_pkg::CW-1:0] center_b_x_i,
  input  logic signed [ssc_pkg::CW-1:0] center_b_y_i,
  input  logic signed [ssc_pkg::CW-1:0] center_b_z_i,
  input  logic [ssc_pkg::CW-2:0]     radius_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic signed [ssc_pkg::NW-1:0] normal_x_o,
  output logic signed [ssc_pkg::NW-1:0] normal_y_o,
  output logic signed [ssc_pkg::NW-1:0] normal_z_o,
  output logic [ssc_pkg::CW-1:0]     penetration_o,
  output logic signed [ssc_pkg::CW-1:0] contact_x_o,
  output logic signed [ssc_pkg::CW-1:0] contact_y_o,
  output logic signed [ssc_pkg::CW-1:0] contact_z_o
);
  import ssc_pkg::*;

  logic            en;
  logic [15:0]     eps_q;
  logic [NSTG-1:0] vld_q;
  logic            sk_valid_q;

  // Pipeline advances unless the skid register holds a stalled result.
  assign en          = !sk_valid_q;
  assign in_stall_o  = sk_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = sk_valid_q || vld_q[NSTG-1];

  // Configuration register, valid chain and skid valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q      <= EPS_RESET;
      vld_q      <= '0;
      sk_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        eps_q <= cfg_data_i;
      end
      if (en) begin
        vld_q <= {vld_q[NSTG-2:0], in_valid_i};
      end
      if (sk_valid_q) begin
        if (!out_stall_i) begin
          sk_valid_q <= 1'b0;
        end
      end else if (vld_q[NSTG-1] && out_stall_i) begin
        sk_valid_q <= 1'b1;
      end
    end
  end

  // Front stage: centre differences as sign and magnitude.
  logic [2:0][CW-1:0] ca;
  logic [2:0][CW-1:0] cb;
  fr_ctx_t            fr_in;
  fr_ctx_t            fr_ctx_q [FR_N];

  assign ca = {center_a_z_i, center_a_y_i, center_a_x_i};
  assign cb = {center_b_z_i, center_b_y_i, center_b_x_i};

  always_comb begin
    logic [DW-1:0] dx;
    fr_in.a  = ca;
    fr_in.ra = radius_a_i;
    fr_in.rb = radius_b_i;
    for (int l = 0; l < 3; l++) begin
      dx = {cb[l][CW-1], cb[l]} - {ca[l][CW-1], ca[l]};
      fr_in.dneg[l] = dx[DW-1];
      fr_in.dmag[l] = dx[DW-1] ? DW'(-dx) : dx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_ctx_q[0] <= fr_in;
      for (int k = 1; k < FR_N; k++) begin
        fr_ctx_q[k] <= fr_ctx_q[k-1];
      end
    end
  end

  // Squares, then their sum.
  logic [SQW-1:0] sq_q [3];
  logic [SQW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sq_q[l] <= SQW'(fr_ctx_q[0].dmag[l]) * SQW'(fr_ctx_q[0].dmag[l]);
      end
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // Row of root cells, one distance bit each.
  logic [REMW-1:0] rem_w  [RTW+1];
  logic [RTW-1:0]  root_w [RTW+1];
  logic [SQW-1:0]  rad_w  [RTW+1];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = sum_q;

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    ssc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_w[j]),
      .root_i (root_w[j]),
      .rad_i  (rad_w[j]),
      .rem_o  (rem_w[j+1]),
      .root_o (root_w[j+1]),
      .rad_o  (rad_w[j+1])
    );
  end

  // Setup stage: hit test, penetration, lever and normal dividends.
  logic [RTW-1:0]  cdist;
  logic [CW-1:0]   rsum;
  fr_ctx_t         fr_last;
  bk_ctx_t         bk_in;
  logic [NUMW-1:0] num [3];
  bk_ctx_t         bk_ctx_q [QW+1];
  logic [CW-1:0]   den_w  [3][QW+1];
  logic [CW-1:0]   drem_w [3][QW+1];
  logic [QW-1:0]   dlow_w [3][QW+1];
  logic [QW-1:0]   quo_w  [3][QW+1];
  logic [CW-1:0]   den_q;
  logic [CW-1:0]   drem_q [3];
  logic [QW-1:0]   dlow_q [3];

  assign cdist   = root_w[RTW];
  assign fr_last = fr_ctx_q[FR_N-1];
  assign rsum    = CW'(fr_last.ra) + CW'(fr_last.rb);

  always_comb begin
    bk_in.a    = fr_last.a;
    bk_in.dneg = fr_last.dneg;
    bk_in.hit  = cdist <= {1'b0, rsum};
    bk_in.near = cdist <= RTW'(eps_q);
    bk_in.pen  = rsum - cdist[CW-1:0];
    bk_in.s2   = S2W'(fr_last.ra) - S2W'(fr_last.rb) + S2W'(cdist);
    for (int l = 0; l < 3; l++) begin
      num[l] = (NUMW'(fr_last.dmag[l][CW-1:0]) << NFB) + NUMW'(cdist[RTW-1:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bk_ctx_q[0] <= bk_in;
      den_q       <= cdist[CW-1:0];
      for (int l = 0; l < 3; l++) begin
        drem_q[l] <= num[l][NUMW-1:QW];
        dlow_q[l] <= num[l][QW-1:0];
      end
      for (int k = 1; k <= QW; k++) begin
        bk_ctx_q[k] <= bk_ctx_q[k-1];
      end
    end
  end

  // Three rows of divide cells, one normal bit each.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign den_w[l][0]  = den_q;
    assign drem_w[l][0] = drem_q[l];
    assign dlow_w[l][0] = dlow_q[l];
    assign quo_w[l][0]  = '0;
    for (genvar k = 0; k < QW; k++) begin : g_div
      ssc_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .den_i (den_w[l][k]),
        .rem_i (drem_w[l][k]),
        .low_i (dlow_w[l][k]),
        .quo_i (quo_w[l][k]),
        .den_o (den_w[l][k+1]),
        .rem_o (drem_w[l][k+1]),
        .low_o (dlow_w[l][k+1]),
        .quo_o (quo_w[l][k+1])
      );
    end
  end

  // Normal selection, with the upward default for near-coincident centres.
  bk_ctx_t       e_ctx_q;
  logic [QW-1:0] e_nmag_q [3];
  logic [2:0]    e_nneg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ctx_q <= bk_ctx_q[QW];
      for (int l = 0; l < 3; l++) begin
        if (bk_ctx_q[QW].near) begin
          e_nmag_q[l] <= (l == 1) ? QW'(1 << NFB) : '0;
          e_nneg_q[l] <= 1'b0;
        end else begin
          e_nmag_q[l] <= quo_w[l][QW];
          e_nneg_q[l] <= bk_ctx_q[QW].dneg[l];
        end
      end
    end
  end

  // Offset products of normal and lever.
  logic [S2W-2:0] s2mag;
  bk_ctx_t        f_ctx_q;
  logic [PW-1:0]  f_prod_q [3];
  logic [2:0]     f_sub_q;
  logic [NW-1:0]  f_norm_q [3];

  assign s2mag = e_ctx_q.s2[S2W-1] ? (S2W-1)'(-e_ctx_q.s2) : e_ctx_q.s2[S2W-2:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ctx_q <= e_ctx_q;
      for (int l = 0; l < 3; l++) begin
        f_prod_q[l] <= PW'(e_nmag_q[l]) * PW'(s2mag);
        f_sub_q[l]  <= e_nneg_q[l] ^ e_ctx_q.s2[S2W-1];
        f_norm_q[l] <= e_nneg_q[l] ? NW'(-{1'b0, e_nmag_q[l]}) : NW'(e_nmag_q[l]);
      end
    end
  end

  // Contact point: round the offset, add to centre A, saturate.
  logic [CW-1:0] cont [3];

  always_comb begin
    logic [PW-1:0]    rnd;
    logic [PW-QW-1:0] off;
    logic [CEW-1:0]   cx;
    logic [CEW-1:0]   aext;
    for (int l = 0; l < 3; l++) begin
      rnd  = f_prod_q[l] + PW'(1 << NFB);
      off  = rnd[PW-1:QW];
      aext = {{(CEW - CW){f_ctx_q.a[l][CW-1]}}, f_ctx_q.a[l]};
      cx   = f_sub_q[l] ? aext - CEW'(off) : aext + CEW'(off);
      if (cx[CEW-1:CW-1] == '0 || cx[CEW-1:CW-1] == '1) begin
        cont[l] = cx[CW-1:0];
      end else if (cx[CEW-1]) begin
        cont[l] = {1'b1, {(CW - 1){1'b0}}};
      end else begin
        cont[l] = {1'b0, {(CW - 1){1'b1}}};
      end
    end
  end

  // Output register; a miss reports all zeros.
  logic                hit_q;
  logic [2:0][NW-1:0]  norm_q;
  logic [CW-1:0]       pen_q;
  logic [2:0][CW-1:0]  cont_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= f_ctx_q.hit;
      pen_q <= f_ctx_q.hit ? f_ctx_q.pen : '0;
      for (int l = 0; l < 3; l++) begin
        norm_q[l] <= f_ctx_q.hit ? f_norm_q[l] : '0;
        cont_q[l] <= f_ctx_q.hit ? cont[l] : '0;
      end
    end
  end

  // Skid register: it takes a result that is stalled at the output, so the
  // input stall comes straight from a register.
  logic                sk_hit_q;
  logic [2:0][NW-1:0]  sk_norm_q;
  logic [CW-1:0]       sk_pen_q;
  logic [2:0][CW-1:0]  sk_cont_q;

  always_ff @(posedge clk_i) begin
    if (!sk_valid_q && vld_q[NSTG-1] && out_stall_i) begin
      sk_hit_q  <= hit_q;
      sk_norm_q <= norm_q;
      sk_pen_q  <= pen_q;
      sk_cont_q <= cont_q;
    end
  end

  assign hit_o         = sk_valid_q ? sk_hit_q     : hit_q;
  assign normal_x_o    = sk_valid_q ? sk_norm_q[0] : norm_q[0];
  assign normal_y_o    = sk_valid_q ? sk_norm_q[1] : norm_q[1];
  assign normal_z_o    = sk_valid_q ? sk_norm_q[2] : norm_q[2];
  assign penetration_o = sk_valid_q ? sk_pen_q     : pen_q;
  assign contact_x_o   = sk_valid_q ? sk_cont_q[0] : cont_q[0];
  assign contact_y_o   = sk_valid_q ? sk_cont_q[1] : cont_q[1];
  assign contact_z_o   = sk_valid_q ? sk_cont_q[2] : cont_q[2];

endmodule

/* test/sphere_sphere_contact_top_tb.sv */
`timescale 1ns / 1ps

module sphere_sphere_contact_top_tb;
  import ssc_pkg::*;

  localparam int LATENCY   = 55;
  localparam int MAX_CYCLE = 600000;
  localparam int NORM_ONE  = 1 << NFB;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic [CW-2:0]        ra;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic [CW-2:0]        rb;
  } sphere_pair_t;

  typedef struct packed {
    logic                 hit;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic [CW-1:0]        pen;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } contact_t;

  typedef struct {
    sphere_pair_t pair;
    bit           typed;
    contact_t     want;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic cfg_ready;
  logic in_valid = 1'b0;
  logic in_stall;
  sphere_pair_t pair_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  contact_t got;

  sphere_sphere_contact_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .center_a_x_i  (pair_q.ax),
    .center_a_y_i  (pair_q.ay),
    .center_a_z_i  (pair_q.az),
    .radius_a_i    (pair_q.ra),
    .center_b_x_i  (pair_q.bx),
    .center_b_y_i  (pair_q.by),
    .center_b_z_i  (pair_q.bz),
    .radius_b_i    (pair_q.rb),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .hit_o         (got.hit),
    .normal_x_o    (got.nx),
    .normal_y_o    (got.ny),
    .normal_z_o    (got.nz),
    .penetration_o (got.pen),
    .contact_x_o   (got.cx),
    .contact_y_o   (got.cy),
    .contact_z_o   (got.cz)
  );

  // Clock and cycle limit.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int cycle = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Predictor state: the near-zero distance threshold.
  logic [15:0] near_eps = EPS_RESET;
  int errors = 0;

  contact_t expected_contacts[$];
  pair_row_t offered_rows[$];

  task automatic report(input string what, input longint seen, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, seen, want);
    errors++;
  endtask

  // Unit normal component: rounded |d| / distance in Q1.14, sign of d.
  function automatic longint normal_of(input longint d, input logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (d < 0) ? -d : d;
    q = ((mag << NFB) + (den >> 1)) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Contact coordinate: a + n * s2 / 2^(NFB+1), rounded, then saturated.
  function automatic logic [CW-1:0] contact_of(input longint a, input longint n,
                                              input longint s2);
    longint mag;
    longint off;
    longint c;
    mag = ((n < 0) ? -n : n) * ((s2 < 0) ? -s2 : s2);
    off = (mag + (longint'(1) << NFB)) >>> (NFB + 1);
    c = ((n < 0) != (s2 < 0)) ? a - off : a + off;
    if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
    if (c < -64'sh8000_0000) c = -64'sh8000_0000;
    return c[CW-1:0];
  endfunction

  function automatic contact_t predict_contact(input sphere_pair_t p);
    longint ax, ay, az, dx, dy, dz, nx, ny, nz, s2;
    logic [127:0] mx, my, mz, sq, root, cand, rsum;
    contact_t r;
    ax = p.ax; ay = p.ay; az = p.az;
    dx = longint'(p.bx) - ax;
    dy = longint'(p.by) - ay;
    dz = longint'(p.bz) - az;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    mz = (dz < 0) ? -dz : dz;
    sq = mx * mx + my * my + mz * mz;
    root = '0;
    for (int b = 62; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    rsum = 128'(p.ra) + 128'(p.rb);
    r = '0;
    if (root > rsum) return r;
    if (root > 128'(near_eps)) begin
      nx = normal_of(dx, root);
      ny = normal_of(dy, root);
      nz = normal_of(dz, root);
    end else begin
      nx = 0;
      ny = NORM_ONE;
      nz = 0;
    end
    s2 = longint'(p.ra) - longint'(p.rb) + longint'(root);
    r.hit = 1'b1;
    r.nx = nx[NW-1:0];
    r.ny = ny[NW-1:0];
    r.nz = nz[NW-1:0];
    r.pen = rsum[CW-1:0] - root[CW-1:0];
    r.cx = contact_of(ax, nx, s2);
    r.cy = contact_of(ay, ny, s2);
    r.cz = contact_of(az, nz, s2);
    return r;
  endfunction

  // Record input transfers first, then check output transfers.
  always @(posedge clk) begin
    pair_row_t row;
    contact_t want;
    if (in_valid && !in_stall) begin
      row = offered_rows.pop_front();
      expected_contacts.push_back(row.typed ? row.want : predict_contact(pair_q));
    end
    if (out_valid && !out_stall) begin
      if (expected_contacts.size() == 0) begin
        report("unexpected result, hit", got.hit, 0);
      end else begin
        want = expected_contacts.pop_front();
        if (got.hit !== want.hit) report("hit", got.hit, want.hit);
        if (got.nx !== want.nx) report("normal_x", got.nx, want.nx);
        if (got.ny !== want.ny) report("normal_y", got.ny, want.ny);
        if (got.nz !== want.nz) report("normal_z", got.nz, want.nz);
        if (got.pen !== want.pen) report("penetration", got.pen, want.pen);
        if (got.cx !== want.cx) report("contact_x", got.cx, want.cx);
        if (got.cy !== want.cy) report("contact_y", got.cy, want.cy);
        if (got.cz !== want.cz) report("contact_z", got.cz, want.cz);
      end
    end
  end

  // Receiver stall: one of four stall modes, chosen at random, plus requested long hold-offs.
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = 400;
    end
    if (cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (cycle % 7) < 3;
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Sender: bursts of random length with random gaps.
  int burst_left = 1;

  task automatic offer_pair(input pair_row_t row);
    int gap;
    offered_rows.push_back(row);
    pair_q <= row.pair;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 20);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_near_eps(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    near_eps = value;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic sphere_pair_t mk(input longint ax, input longint ay, input longint az,
                                     input longint ra, input longint bx, input longint by,
                                     input longint bz, input longint rb);
    sphere_pair_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.az = CW'(az); p.ra = (CW-1)'(ra);
    p.bx = CW'(bx); p.by = CW'(by); p.bz = CW'(bz); p.rb = (CW-1)'(rb);
    return p;
  endfunction

  function automatic contact_t mkc(input longint nx, input longint ny, input longint nz,
                                   input longint pen, input longint cx, input longint cy,
                                   input longint cz);
    contact_t c;
    c.hit = 1'b1; c.nx = NW'(nx); c.ny = NW'(ny); c.nz = NW'(nz);
    c.pen = CW'(pen); c.cx = CW'(cx); c.cy = CW'(cy); c.cz = CW'(cz);
    return c;
  endfunction

  function automatic longint rnd32();
    return longint'($signed($urandom()));
  endfunction

  // Random pair: mostly overlapping neighbors, some near-coincident, some raw noise.
  function automatic sphere_pair_t random_pair();
    sphere_pair_t p;
    int kind;
    int sh;
    kind = $urandom_range(0, 9);
    p.ax = $urandom(); p.ay = $urandom(); p.az = $urandom();
    p.ra = (CW-1)'($urandom()); p.rb = (CW-1)'($urandom());
    p.bx = $urandom(); p.by = $urandom(); p.bz = $urandom();
    if (kind < 6) begin
      sh = $urandom_range(2, 31);
      p.bx = CW'(p.ax + (rnd32() >>> sh));
      p.by = CW'(p.ay + (rnd32() >>> sh));
      p.bz = CW'(p.az + (rnd32() >>> sh));
      p.ra = (CW-1)'($urandom() >> $urandom_range(sh - 1, 31));
      p.rb = (CW-1)'($urandom() >> $urandom_range(sh - 1, 31));
    end else if (kind < 8) begin
      p.bx = p.ax + $urandom_range(0, 64) - 32;
      p.by = p.ay + $urandom_range(0, 64) - 32;
      p.bz = p.az + $urandom_range(0, 64) - 32;
      p.ra = (CW-1)'($urandom_range(0, 200));
    end
    return p;
  endfunction

  pair_row_t dir_rows[$];

  initial begin
    pair_row_t row;
    contact_t miss;
    miss = '0;

    // Directed rows, typed where the answer is plain.
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1,
                         mkc(0, NORM_ONE, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0), 1, miss});
    dir_rows.push_back('{mk(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                            31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 31'h7FFF_FFFF), 1, miss});
    dir_rows.push_back('{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF),
                         1, mkc(0, NORM_ONE, 0, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF)});
    // Contact pushed past the positive limit saturates.
    dir_rows.push_back('{mk(0, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0), 1,
                         mkc(0, NORM_ONE, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0)});
    // Contact pushed past the negative limit saturates.
    dir_rows.push_back('{mk(0, -32'sh8000_0000, 0, 0, 0, -32'sh8000_0000, 0, 31'h7FFF_FFFF),
                         1, mkc(0, NORM_ONE, 0, 32'h7FFF_FFFF, 0, -32'sh8000_0000, 0)});
    dir_rows.push_back('{mk(0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h1_0000), 1,
                         mkc(NORM_ONE, 0, 0, 32'h1_0000, 32'h8000, 0, 0)});
    dir_rows.push_back('{mk(0, 0, 0, 32'h1_0000, -32'sh1_0000, 0, 0, 32'h1_0000), 1,
                         mkc(-NORM_ONE, 0, 0, 32'h1_0000, -32'sh8000, 0, 0)});
    dir_rows.push_back('{mk(0, 0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h1_0000), 1,
                         mkc(0, 0, NORM_ONE, 32'h1_0000, 0, 0, 32'h8000)});
    // Predictor rows: threshold edges, exact touch, one past touch, diagonals.
    dir_rows.push_back('{mk(5, 5, 5, 32'h100, 12, 5, 5, 0), 0, miss});
    dir_rows.push_back('{mk(5, 5, 5, 32'h100, 13, 5, 5, 0), 0, miss});
    dir_rows.push_back('{mk(0, 0, 0, 32'h1_0000, 32'h2_0000, 0, 0, 32'h1_0000), 0, miss});
    dir_rows.push_back('{mk(0, 0, 0, 32'h1_0000, 32'h2_0001, 0, 0, 32'h1_0000), 0, miss});
    dir_rows.push_back('{mk(32'h1234_5678, -32'sh2345_6789, 32'h0FED_CBA9, 32'h3000_0000,
                            32'h1334_5678, -32'sh2245_6789, 32'h0EED_CBA9, 32'h100_0000),
                         0, miss});
    dir_rows.push_back('{mk(-32'sh7000_0000, 32'h7000_0000, -32'sh10, 31'h7FFF_FFFF,
                            32'h7000_0000, -32'sh7000_0000, 32'h10, 31'h7FFF_FFFF),
                         0, miss});
    dir_rows.push_back('{mk(100, 200, 300, 0, 103, 196, 300, 5), 0, miss});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) offer_pair(dir_rows[i]);
    wait_drained();

    // Random phases under several thresholds, the extremes among them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_near_eps(16'h0000);
        1: write_near_eps(16'hFFFF);
        2: write_near_eps(16'($urandom()));
        default: write_near_eps(EPS_RESET);
      endcase
      @(posedge clk);
      if (ph == 1) hold_req++;
      for (int n = 0; n < 485; n++) begin
        row.pair = random_pair();
        row.typed = 1'b0;
        row.want = '0;
        offer_pair(row);
        if (ph == 3 && n == 200) hold_req++;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ssc_pkg.sv
rtl/core/ssc_sqrt_cell.sv
rtl/core/ssc_div_cell.sv
rtl/core/sphere_sphere_contact_top.sv
test/sphere_sphere_contact_top_tb.sv
